>>> rtl/core/knn_pkg.sv
// knn_pkg: shared types and codes for the point search block
// depends on nothing
`timescale 1ns / 1ps
package knn_pkg;
	localparam int unsigned CW = 24;

	typedef enum logic [1:0] {
		REQ_ADD = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_STORED = 3'd0,
		ST_FULL = 3'd1,
		ST_NEIGHBOR = 3'd2,
		ST_EMPTY = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [CW-1:0] coord_x;
		logic signed [CW-1:0] coord_y;
		logic signed [CW-1:0] coord_z;
		logic [5:0] k_count;
		logic [22:0] max_radius;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [9:0] object_index;
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic signed [CW-1:0] pos_z;
		logic [24:0] distance;
		logic last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;     // capture the input item
		logic store_wr;    // write the add point
		logic scan_start;  // reset scan counters and best list
		logic scan_step;   // advance the scan by one step
		logic emit_start;  // begin reading best entry
		logic emit_next;   // advance emit index
		logic sqrt_start;
		logic out_load;    // load output register from current entry
		logic [2:0] out_kind; // which status to present
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic scan_done;
		logic sqrt_done;
		logic emit_last;
		logic best_empty;
		logic out_busy;
	} dp_sts_t;
endpackage

>>> rtl/core/knn_point_search.sv
// knn_point_search: point store with brute-force k nearest neighbor search
// add and clear each load one status output; a query scans every stored point and then
// reports each neighbor after its distance passes the bit-serial square root
// one item is in work at a time; scan runs one stored point per cycle on one ram port
// reset empties the store count and the best list; store contents stay undefined
`timescale 1ns / 1ps
module knn_point_search #(
	parameter int unsigned MAX_POINTS = 1024,
	parameter int unsigned MAX_K = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input knn_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output knn_pkg::out_item_t out_data
);
	import knn_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	knn_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.req(req_t'(in_data.req_type)),
		.in_stall(in_stall),
		.cmd(cmd),
		.sts(sts)
	);

	knn_datapath #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_K(MAX_K)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_data),
		.cmd(cmd),
		.sts(sts),
		.out_item(out_data),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);
endmodule

>>> rtl/core/knn_ram.sv
// knn_ram: generic single write, single read memory with registered read
// depends on nothing
`timescale 1ns / 1ps
module knn_ram #(
	parameter int unsigned WIDTH = 72,
	parameter int unsigned DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/core/knn_sqrt.sv
// knn_sqrt: iterative floor square root, one root bit per cycle
// depends on nothing
`timescale 1ns / 1ps
module knn_sqrt #(
	parameter int unsigned IN_BITS = 50
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [IN_BITS-1:0] radicand,
	output logic done,
	output logic [IN_BITS/2:0] root
);
	localparam int unsigned NB = (IN_BITS + 1) / 2;
	localparam int unsigned RW = 2 * NB;
	localparam int unsigned CNTW = $clog2(NB + 1);

	logic [RW-1:0] rem_q;
	logic [RW-1:0] src_q;
	logic [NB-1:0] res_q;
	logic [CNTW-1:0] cnt_q;
	logic busy_q;
	logic [RW+1:0] trial;
	logic [RW+1:0] rem_sh;

	assign rem_sh = {rem_q, src_q[RW-1 -: 2]};
	assign trial = rem_sh - {{(RW-NB){1'b0}}, res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// restoring digit-by-digit method, one root bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			res_q <= '0;
			src_q <= RW'(radicand);
		end else if (busy_q) begin
			src_q <= {src_q[RW-3:0], 2'b00};
			if (!trial[RW+1]) begin
				rem_q <= trial[RW-1:0];
				res_q <= {res_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[RW-1:0];
				res_q <= {res_q[NB-2:0], 1'b0};
			end
		end
	end

	assign root = (IN_BITS/2+1)'(res_q);
endmodule

>>> rtl/core/knn_datapath.sv
// knn_datapath: point store, distance pipeline, sorted best list, output register
// depends on knn_pkg, knn_ram, knn_sqrt
`timescale 1ns / 1ps
module knn_datapath #(
	parameter int unsigned MAX_POINTS = 1024,
	parameter int unsigned MAX_K = 32
) (
	input logic clk,
	input logic arst_n,
	input knn_pkg::in_item_t in_item,
	input knn_pkg::dp_cmd_t cmd,
	output knn_pkg::dp_sts_t sts,
	output knn_pkg::out_item_t out_item,
	output logic out_valid,
	input logic out_stall
);
	import knn_pkg::*;

	localparam int unsigned COORD_BITS = CW;
	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
	localparam int unsigned KW = $clog2(MAX_K + 1);
	localparam int unsigned KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned SQW = 2 * DW;
	localparam int unsigned D2W = SQW + 2;

	logic [CNTW-1:0] count_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
	logic [22:0] rad_q;
	logic [45:0] r2_q;
	logic [KW-1:0] k_q;

	// point store
	logic [3*COORD_BITS-1:0] rdata;
	logic [AW-1:0] raddr;
	logic [AW-1:0] scan_addr_q;
	logic [CNTW-1:0] issued_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load_in && in_item.req_type == REQ_CLEAR) begin
			count_q <= '0;
		end else if (cmd.store_wr) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			qx_q <= COORD_BITS'(in_item.coord_x);
			qy_q <= COORD_BITS'(in_item.coord_y);
			qz_q <= COORD_BITS'(in_item.coord_z);
			rad_q <= in_item.max_radius;
			r2_q <= in_item.max_radius * in_item.max_radius;
			k_q <= (7'(in_item.k_count) > 7'(MAX_K)) ? KW'(MAX_K) : KW'(in_item.k_count);
		end
	end

	assign sts.full = (count_q == CNTW'(MAX_POINTS));

	knn_ram #(.WIDTH(3 * COORD_BITS), .DEPTH(MAX_POINTS)) u_store (
		.clk(clk),
		.we(cmd.store_wr),
		.waddr(count_q[AW-1:0]),
		.wdata({qx_q, qy_q, qz_q}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// scan pipeline: s1 read, s2 abs diff, s3 squares, s4 sum/compare, then insert
	logic v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [DW-1:0] dx_s2, dy_s2, dz_s2;
	logic rej_s2, rej_s3;
	logic [SQW-1:0] sx_s3, sy_s3, sz_s3;
	logic [D2W-1:0] d2_s4;
	logic ok_s4;

	logic signed [DW-1:0] px, py, pz, ex, ey, ez;
	logic [DW-1:0] ax, ay, az;
	assign px = DW'(signed'(rdata[3*COORD_BITS-1 -: COORD_BITS]));
	assign py = DW'(signed'(rdata[2*COORD_BITS-1 -: COORD_BITS]));
	assign pz = DW'(signed'(rdata[COORD_BITS-1:0]));
	assign ex = px - DW'(qx_q);
	assign ey = py - DW'(qy_q);
	assign ez = pz - DW'(qz_q);
	assign ax = ex[DW-1] ? DW'(-ex) : DW'(ex);
	assign ay = ey[DW-1] ? DW'(-ey) : DW'(ey);
	assign az = ez[DW-1] ? DW'(-ez) : DW'(ez);

	// emit read address shares the store port; the emit select is held for the whole emit phase
	logic [KIW-1:0] emit_i_q;
	logic [AW-1:0] best_idx [MAX_K];
	logic [D2W-1:0] best_d2 [MAX_K];
	logic [KW-1:0] fill_q;
	logic emit_sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_sel_q <= 1'b0;
		end else if (cmd.scan_start) begin
			emit_sel_q <= 1'b0;
		end else if (cmd.emit_start) begin
			emit_sel_q <= 1'b1;
		end
	end

	assign raddr = emit_sel_q ? best_idx[emit_i_q] : scan_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			issued_q <= '0;
		end else if (cmd.scan_start) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			issued_q <= '0;
		end else if (cmd.scan_step) begin
			v_s1 <= (issued_q < count_q) && (k_q != '0);
			if (issued_q < count_q) begin
				issued_q <= issued_q + 1'b1;
			end
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			scan_addr_q <= '0;
		end else if (cmd.scan_step) begin
			if (issued_q < count_q) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			idx_s1 <= scan_addr_q;
			idx_s2 <= idx_s1;
			dx_s2 <= ax;
			dy_s2 <= ay;
			dz_s2 <= az;
			rej_s2 <= (ax > DW'(rad_q)) || (ay > DW'(rad_q)) || (az > DW'(rad_q));
			idx_s3 <= idx_s2;
			rej_s3 <= rej_s2;
			sx_s3 <= dx_s2 * dx_s2;
			sy_s3 <= dy_s2 * dy_s2;
			sz_s3 <= dz_s2 * dz_s2;
			idx_s4 <= idx_s3;
			d2_s4 <= D2W'(sx_s3) + D2W'(sy_s3) + D2W'(sz_s3);
			ok_s4 <= !rej_s3 && (D2W'(sx_s3) + D2W'(sy_s3) + D2W'(sz_s3) <= D2W'(r2_q));
		end
	end

	assign sts.scan_done = (issued_q == count_q || k_q == '0) && !v_s1 && !v_s2 && !v_s3
		&& !v_s4;

	// sorted insert: each slot compares with the new key in parallel and shifts
	logic ins_en;
	logic full_k;
	logic [D2W-1:0] tail_d2;
	assign full_k = (fill_q >= k_q);
	assign tail_d2 = best_d2[KIW'(k_q - 1'b1)];
	assign ins_en = cmd.scan_step && v_s4 && ok_s4 && (!full_k || d2_s4 < tail_d2);

	logic [MAX_K-1:0] gt;
	always_comb begin
		for (int j = 0; j < MAX_K; j++) begin
			gt[j] = (KW'(j) < fill_q) && (best_d2[j] > d2_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.scan_start) begin
			fill_q <= '0;
		end else if (ins_en && !full_k) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			for (int j = 0; j < MAX_K; j++) begin
				if (gt[j]) begin
					if (j == 0 || gt[(j == 0) ? 0 : j - 1]) begin
						if (j > 0) begin
							best_d2[j] <= best_d2[(j == 0) ? 0 : j - 1];
							best_idx[j] <= best_idx[(j == 0) ? 0 : j - 1];
						end else begin
							best_d2[j] <= d2_s4;
							best_idx[j] <= idx_s4;
						end
					end else begin
						best_d2[j] <= d2_s4;
						best_idx[j] <= idx_s4;
					end
				end else if (KW'(j) == fill_q && !full_k) begin
					// slot past the end takes the shifted tail or the new entry
					if (j > 0 && gt[(j == 0) ? 0 : j - 1]) begin
						best_d2[j] <= best_d2[(j == 0) ? 0 : j - 1];
						best_idx[j] <= best_idx[(j == 0) ? 0 : j - 1];
					end else begin
						best_d2[j] <= d2_s4;
						best_idx[j] <= idx_s4;
					end
				end
			end
		end
	end

	// emit: read point, take square root, load output register
	logic sqrt_done;
	logic [SQW/2+1:0] root;
	knn_sqrt #(.IN_BITS(D2W)) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.sqrt_start),
		.radicand(best_d2[emit_i_q]),
		.done(sqrt_done),
		.root(root)
	);
	assign sts.sqrt_done = sqrt_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_i_q <= '0;
		end else if (cmd.scan_start) begin
			emit_i_q <= '0;
		end else if (cmd.emit_next) begin
			emit_i_q <= emit_i_q + 1'b1;
		end
	end

	assign sts.emit_last = (KW'(emit_i_q) + 1'b1 == fill_q);
	assign sts.best_empty = (fill_q == '0);

	// output register
	logic out_take;
	out_item_t out_d;
	assign out_take = out_valid && !out_stall;
	assign sts.out_busy = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_take) begin
			out_valid <= 1'b0;
		end
	end

	always_comb begin
		out_d = '0;
		out_d.status = cmd.out_kind;
		out_d.last = 1'b1;
		case (status_t'(cmd.out_kind))
			ST_STORED: begin
				out_d.object_index = 10'(count_q);
				out_d.pos_x = 24'(qx_q);
				out_d.pos_y = 24'(qy_q);
				out_d.pos_z = 24'(qz_q);
			end
			ST_FULL: begin
				out_d.pos_x = 24'(qx_q);
				out_d.pos_y = 24'(qy_q);
				out_d.pos_z = 24'(qz_q);
			end
			ST_NEIGHBOR: begin
				out_d.object_index = 10'(best_idx[emit_i_q]);
				out_d.pos_x = 24'(rdata[3*COORD_BITS-1 -: COORD_BITS]);
				out_d.pos_y = 24'(rdata[2*COORD_BITS-1 -: COORD_BITS]);
				out_d.pos_z = 24'(rdata[COORD_BITS-1:0]);
				out_d.distance = 25'(root);
				out_d.last = sts.emit_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_item <= out_d;
		end
	end
endmodule

>>> rtl/core/knn_ctrl.sv
// knn_ctrl: sequencing of add, clear, scan and result emission
// depends on knn_pkg
`timescale 1ns / 1ps
module knn_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input knn_pkg::req_t req,
	output logic in_stall,
	output knn_pkg::dp_cmd_t cmd,
	input knn_pkg::dp_sts_t sts
);
	import knn_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ADD   = 7'b0000010,
		S_CLEAR = 7'b0000100,
		S_SCAN  = 7'b0001000,
		S_READ  = 7'b0010000,
		S_ROOT  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic take;

	assign in_stall = (state_q != S_IDLE) || sts.out_busy;
	assign take = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd.load_in = 1'b1;
					case (req)
						REQ_ADD: state_d = S_ADD;
						REQ_CLEAR: state_d = S_CLEAR;
						REQ_QUERY: state_d = S_SCAN;
						default: state_d = S_IDLE;
					endcase
					cmd.scan_start = (req == REQ_QUERY);
				end
			end
			S_ADD: begin
				cmd.out_load = 1'b1;
				if (sts.full) begin
					cmd.out_kind = ST_FULL;
				end else begin
					cmd.out_kind = ST_STORED;
					cmd.store_wr = 1'b1;
				end
				state_d = S_IDLE;
			end
			S_CLEAR: begin
				cmd.out_load = 1'b1;
				cmd.out_kind = ST_CLEARED;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					if (sts.best_empty) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = ST_EMPTY;
						state_d = S_IDLE;
					end else begin
						cmd.emit_start = 1'b1;
						cmd.sqrt_start = 1'b1;
						state_d = S_ROOT;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_READ: begin
				cmd.emit_start = 1'b1;
				cmd.sqrt_start = 1'b1;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				if (sts.sqrt_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = ST_NEIGHBOR;
					if (sts.emit_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.emit_next = 1'b1;
						state_d = S_READ;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
